### design/rmes_pkg.sv
// ----------------------------------------------------------------------------
// rmes_pkg
// Shared types and constants for the motor and encoder bus slave.
// ----------------------------------------------------------------------------
`default_nettype none

package rmes_pkg;

    // event kinds carried in the input tuser
    typedef enum logic [3:0] {
        KIND_TICK        = 4'd0,
        KIND_LEFT_EDGE   = 4'd1,
        KIND_RIGHT_EDGE  = 4'd2,
        KIND_WRITE_START = 4'd3,
        KIND_WRITE_BYTE  = 4'd4,
        KIND_WRITE_STOP  = 4'd5,
        KIND_READ_START  = 4'd6,
        KIND_READ_NEXT   = 4'd7,
        KIND_POLL        = 4'd8
    } kind_t;

    // configuration register indexes
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TICK_DIVIDE   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT_LIMIT = 1'b1;

    localparam logic [7:0] TICK_DIVIDE_RESET   = 8'd20;
    localparam logic [7:0] TIMEOUT_LIMIT_RESET = 8'd2;

    // sensor slots returned by reads, in turn
    localparam logic [2:0] SLOT_BUMPER        = 3'd0;
    localparam logic [2:0] SLOT_COUNT_LEFT    = 3'd1;
    localparam logic [2:0] SLOT_COUNT_RIGHT   = 3'd2;
    localparam logic [2:0] SLOT_CURRENT_HIGH  = 3'd3;
    localparam logic [2:0] SLOT_CURRENT_LOW   = 3'd4;
    localparam logic [2:0] SENSOR_SLOTS       = 3'd5;
    localparam logic [2:0] SLOT_KEEP_MAX      = 3'd2;

    localparam int         COMMAND_BYTES      = 3;
    localparam logic [4:0] COMMAND_BYTES_CNT  = 5'd3;
    localparam logic [4:0] WRITE_COUNT_MAX    = 5'd20;
    localparam logic [1:0] DEBOUNCE_MAX       = 2'd2;
    localparam logic [7:0] TIMEOUT_MAX        = 8'd255;
    localparam logic [15:0] COUNT_PRESET      = 16'd128;

    // direction byte codes that mean forward for each wheel
    localparam logic [7:0] DIR_BOTH_FWD  = 8'h00;
    localparam logic [7:0] DIR_LEFT_FWD  = 8'h04;
    localparam logic [7:0] DIR_RIGHT_FWD = 8'h08;

    // direction bits kept from the first motor byte
    localparam logic [3:0] DIR_MASK      = 4'b1100;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] data_byte;
        logic [1:0] bumper_bits;
        logic [9:0] current_sample;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       read_valid;
        logic [3:0] motor_direction;
        logic [7:0] pwm_left;
        logic [7:0] pwm_right;
    } result_t;

    // handshake between the input register and the result register
    typedef struct packed {
        logic item_valid;
        logic advance;
    } flow_t;

endpackage

`default_nettype wire

### design/rmes_in_reg.sv
// ----------------------------------------------------------------------------
// rmes_in_reg
// Input request register: holds one accepted event until it is processed.
// ----------------------------------------------------------------------------
`default_nettype none

module rmes_in_reg (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [rmes_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic [3:0]                       s_axis_tuser,
    input  wire logic                             take,
    output logic                                  item_valid,
    output rmes_pkg::item_t                       item
);

    logic            valid_reg;
    logic            valid_next;
    rmes_pkg::item_t item_reg;
    logic            accept;

    // free when empty or when the held request moves on this cycle
    assign s_axis_tready = !valid_reg || take;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.kind           <= s_axis_tuser;
            item_reg.data_byte      <= s_axis_tdata[7:0];
            item_reg.bumper_bits    <= s_axis_tdata[9:8];
            item_reg.current_sample <= s_axis_tdata[19:10];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

### design/rmes_state.sv
// ----------------------------------------------------------------------------
// rmes_state
// Slave state and its single-pass update for one event, plus config registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rmes_state (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [rmes_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [7:0]                          cfg_wdata,
    input  wire logic                                advance,
    input  wire rmes_pkg::item_t                     item,
    output rmes_pkg::result_t                        result
);

    logic [7:0]  tick_divide_reg, timeout_limit_reg;
    logic [7:0]  tick_divider_reg, tick_divider_next;
    logic [1:0]  debounce_left_reg, debounce_left_next;
    logic [1:0]  debounce_right_reg, debounce_right_next;
    logic [7:0]  timeout_count_reg, timeout_count_next;
    logic [15:0] count_left_reg, count_left_next;
    logic [15:0] count_right_reg, count_right_next;
    logic [1:0]  bumper_state_reg, bumper_state_next;
    logic [2:0]  current_high_reg, current_high_next;
    logic [6:0]  current_low_reg, current_low_next;
    logic [4:0]  write_count_reg, write_count_next;
    logic [7:0]  write_buffer_reg [rmes_pkg::COMMAND_BYTES];
    logic [7:0]  write_buffer_next [rmes_pkg::COMMAND_BYTES];
    logic [7:0]  received_reg [rmes_pkg::COMMAND_BYTES];
    logic [7:0]  received_next [rmes_pkg::COMMAND_BYTES];
    logic        pending_reg, pending_next;
    logic [7:0]  motor_reg [rmes_pkg::COMMAND_BYTES];
    logic [7:0]  motor_next [rmes_pkg::COMMAND_BYTES];
    logic [2:0]  read_index_reg, read_index_next;

    logic [8:0]  tick_sum;
    logic [2:0]  slot;
    logic [7:0]  slot_byte;
    logic [7:0]  read_data;
    logic        read_valid;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_divide_reg   <= rmes_pkg::TICK_DIVIDE_RESET;
            timeout_limit_reg <= rmes_pkg::TIMEOUT_LIMIT_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                rmes_pkg::CFG_TICK_DIVIDE:   tick_divide_reg   <= cfg_wdata;
                rmes_pkg::CFG_TIMEOUT_LIMIT: timeout_limit_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // slot selection for reads, index past the last slot wraps to the first
    assign slot = (read_index_reg >= rmes_pkg::SENSOR_SLOTS) ?
                  rmes_pkg::SLOT_BUMPER : read_index_reg;

    always_comb begin
        case (slot)
            rmes_pkg::SLOT_BUMPER:       slot_byte = {6'd0, bumper_state_reg};
            rmes_pkg::SLOT_COUNT_LEFT:   slot_byte = count_left_reg[7:0];
            rmes_pkg::SLOT_COUNT_RIGHT:  slot_byte = count_right_reg[7:0];
            rmes_pkg::SLOT_CURRENT_HIGH: slot_byte = {5'd0, current_high_reg};
            default:                     slot_byte = {1'b0, current_low_reg};
        endcase
    end

    assign tick_sum = {1'b0, tick_divider_reg} + 9'd1;

    // event update
    always_comb begin
        tick_divider_next   = tick_divider_reg;
        debounce_left_next  = debounce_left_reg;
        debounce_right_next = debounce_right_reg;
        timeout_count_next  = timeout_count_reg;
        count_left_next     = count_left_reg;
        count_right_next    = count_right_reg;
        bumper_state_next   = bumper_state_reg;
        current_high_next   = current_high_reg;
        current_low_next    = current_low_reg;
        write_count_next    = write_count_reg;
        write_buffer_next   = write_buffer_reg;
        received_next       = received_reg;
        pending_next        = pending_reg;
        motor_next          = motor_reg;
        read_index_next     = read_index_reg;
        read_data           = 8'd0;
        read_valid          = 1'b0;

        case (item.kind)
            rmes_pkg::KIND_TICK: begin
                if (tick_sum > {1'b0, tick_divide_reg}) begin
                    tick_divider_next = 8'd0;
                    if (debounce_left_reg < rmes_pkg::DEBOUNCE_MAX) begin
                        debounce_left_next = debounce_left_reg + 2'd1;
                    end
                    if (debounce_right_reg < rmes_pkg::DEBOUNCE_MAX) begin
                        debounce_right_next = debounce_right_reg + 2'd1;
                    end
                    if (timeout_count_reg != rmes_pkg::TIMEOUT_MAX) begin
                        timeout_count_next = timeout_count_reg + 8'd1;
                    end
                end else begin
                    tick_divider_next = tick_sum[7:0];
                end
            end
            rmes_pkg::KIND_LEFT_EDGE: begin
                if (debounce_left_reg == rmes_pkg::DEBOUNCE_MAX) begin
                    if (motor_reg[0] == rmes_pkg::DIR_BOTH_FWD ||
                        motor_reg[0] == rmes_pkg::DIR_LEFT_FWD) begin
                        count_left_next = count_left_reg + 16'd1;
                    end else begin
                        count_left_next = count_left_reg - 16'd1;
                    end
                    debounce_left_next = 2'd0;
                end
            end
            rmes_pkg::KIND_RIGHT_EDGE: begin
                if (debounce_right_reg == rmes_pkg::DEBOUNCE_MAX) begin
                    if (motor_reg[0] == rmes_pkg::DIR_BOTH_FWD ||
                        motor_reg[0] == rmes_pkg::DIR_RIGHT_FWD) begin
                        count_right_next = count_right_reg + 16'd1;
                    end else begin
                        count_right_next = count_right_reg - 16'd1;
                    end
                    debounce_right_next = 2'd0;
                end
            end
            rmes_pkg::KIND_WRITE_START: begin
                write_count_next = 5'd0;
            end
            rmes_pkg::KIND_WRITE_BYTE: begin
                // only the first few bytes are kept, the count runs on
                for (int k = 0; k < rmes_pkg::COMMAND_BYTES; k++) begin
                    if (write_count_reg == 5'(k)) begin
                        write_buffer_next[k] = item.data_byte;
                    end
                end
                if (write_count_reg < rmes_pkg::WRITE_COUNT_MAX) begin
                    write_count_next = write_count_reg + 5'd1;
                end
            end
            rmes_pkg::KIND_WRITE_STOP: begin
                for (int k = 0; k < rmes_pkg::COMMAND_BYTES; k++) begin
                    if (write_count_reg > 5'(k)) begin
                        received_next[k] = write_buffer_reg[k];
                    end
                    write_buffer_next[k] = 8'd0;
                end
                pending_next       = 1'b1;
                timeout_count_next = 8'd0;
            end
            rmes_pkg::KIND_READ_START: begin
                write_count_next = 5'd0;
                read_data        = slot_byte;
                read_valid       = 1'b1;
                read_index_next  = slot + 3'd1;
            end
            rmes_pkg::KIND_READ_NEXT: begin
                read_data        = slot_byte;
                read_valid       = 1'b1;
                read_index_next  = slot + 3'd1;
                count_left_next  = rmes_pkg::COUNT_PRESET;
                count_right_next = rmes_pkg::COUNT_PRESET;
            end
            rmes_pkg::KIND_POLL: begin
                // sample split into value/128 and value%128
                current_high_next = item.current_sample[9:7];
                current_low_next  = item.current_sample[6:0];
                bumper_state_next = item.bumper_bits;
                if (item.bumper_bits != 2'd0 || timeout_count_reg > timeout_limit_reg) begin
                    for (int k = 0; k < rmes_pkg::COMMAND_BYTES; k++) begin
                        motor_next[k] = 8'd0;
                    end
                end
                if (pending_reg) begin
                    motor_next = received_reg;
                    if (read_index_reg > rmes_pkg::SLOT_KEEP_MAX) begin
                        read_index_next = 3'd0;
                    end
                    pending_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // state registers, updated as each request passes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_divider_reg   <= 8'd0;
            debounce_left_reg  <= 2'd0;
            debounce_right_reg <= 2'd0;
            timeout_count_reg  <= 8'd0;
            count_left_reg     <= 16'd0;
            count_right_reg    <= 16'd0;
            bumper_state_reg   <= 2'd0;
            current_high_reg   <= 3'd0;
            current_low_reg    <= 7'd0;
            write_count_reg    <= 5'd0;
            pending_reg        <= 1'b0;
            read_index_reg     <= 3'd0;
            for (int k = 0; k < rmes_pkg::COMMAND_BYTES; k++) begin
                write_buffer_reg[k] <= 8'd0;
                received_reg[k]     <= 8'd0;
                motor_reg[k]        <= 8'd0;
            end
        end else if (advance) begin
            tick_divider_reg   <= tick_divider_next;
            debounce_left_reg  <= debounce_left_next;
            debounce_right_reg <= debounce_right_next;
            timeout_count_reg  <= timeout_count_next;
            count_left_reg     <= count_left_next;
            count_right_reg    <= count_right_next;
            bumper_state_reg   <= bumper_state_next;
            current_high_reg   <= current_high_next;
            current_low_reg    <= current_low_next;
            write_count_reg    <= write_count_next;
            pending_reg        <= pending_next;
            read_index_reg     <= read_index_next;
            write_buffer_reg   <= write_buffer_next;
            received_reg       <= received_next;
            motor_reg          <= motor_next;
        end
    end

    // result reflects the motor bytes after the update
    always_comb begin
        result.read_data       = read_data;
        result.read_valid      = read_valid;
        result.motor_direction = motor_next[0][3:0] & rmes_pkg::DIR_MASK;
        result.pwm_left        = motor_next[1];
        result.pwm_right       = motor_next[2];
    end

endmodule

`default_nettype wire

### design/rmes_out_reg.sv
// ----------------------------------------------------------------------------
// rmes_out_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rmes_out_reg (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire rmes_pkg::flow_t                   flow,
    input  wire rmes_pkg::result_t                 result,
    output logic                                   out_free,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [rmes_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    output logic [0:0]                             m_axis_tuser
);

    logic              valid_reg;
    logic              valid_next;
    rmes_pkg::result_t result_reg;

    assign out_free = !valid_reg || m_axis_tready;

    always_comb begin
        valid_next = valid_reg;
        if (flow.advance) begin
            valid_next = 1'b1;
        end else if (m_axis_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (flow.advance) begin
            result_reg <= result;
        end
    end

    // pack result fields, lowest first
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {4'd0, result_reg.pwm_right, result_reg.pwm_left,
                            result_reg.motor_direction, result_reg.read_data};
    assign m_axis_tuser  = result_reg.read_valid;

endmodule

`default_nettype wire

### design/robot_motor_encoder_slave.sv
// ----------------------------------------------------------------------------
// robot_motor_encoder_slave
// Bus slave for a two-motor robot: command buffer, encoder counts, sensor reads.
// ----------------------------------------------------------------------------
//  channel  | ports            | contents
//  ---------+------------------+------------------------------------------------
//  input    | s_axis_*         | tuser: event kind; tdata: data byte, bumpers,
//           |                  | current sample
//  result   | m_axis_*         | tuser: read valid; tdata: read byte, direction,
//           |                  | left and right duty
//  config   | cfg_we/addr/wdata| tick divide, timeout limit
//
// One event per cycle while the result side does not stall: each request is held
// in the input register and is turned into its result by one pass of the state
// update logic, whose output is captured in the result register.
// Reset (synchronous, aresetn low) clears all slave state and loads defaults.
// A stalled result holds the result register; the input register still takes
// a request while empty, then waits for the result register to free.
// ----------------------------------------------------------------------------
`default_nettype none

module robot_motor_encoder_slave (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // data_byte[7:0], bumper_bits[9:8], current_sample[19:10], zero fill
    input  wire logic [rmes_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // kind[3:0]
    input  wire logic [3:0]                          s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // read_data[7:0], motor_direction[11:8], pwm_left[19:12], pwm_right[27:20]
    output logic [rmes_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    // read_valid[0]
    output logic [0:0]                               m_axis_tuser,
    input  wire logic                                cfg_we,
    input  wire logic [rmes_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [7:0]                          cfg_wdata
);

    rmes_pkg::item_t   item;
    rmes_pkg::result_t result;
    rmes_pkg::flow_t   flow;
    logic              item_valid;
    logic              out_free;

    // a request moves on when the result register can take its result
    always_comb begin
        flow.item_valid = item_valid;
        flow.advance    = item_valid && out_free;
    end

    rmes_in_reg u_in_reg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .take          (flow.advance),
        .item_valid    (item_valid),
        .item          (item)
    );

    rmes_state u_state (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .advance   (flow.advance),
        .item      (item),
        .result    (result)
    );

    rmes_out_reg u_out_reg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .flow          (flow),
        .result        (result),
        .out_free      (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

### design/rmes_checker.sv
// ----------------------------------------------------------------------------
// rmes_checker
// Port-level checks on the motor and encoder bus slave.
// ----------------------------------------------------------------------------
`default_nettype none

module rmes_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_axis_tvalid,
    input wire logic                                s_axis_tready,
    input wire logic                                m_axis_tvalid,
    input wire logic                                m_axis_tready,
    input wire logic [rmes_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input wire logic [0:0]                          m_axis_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // no read byte unless a read request
    a_read_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'd0)
        else $error("read byte without read");

    // direction keeps only its two direction bits, and the top fill bits stay zero
    a_dir_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[9:8] == 2'b00 && m_axis_tdata[31:28] == 4'd0)
        else $error("direction or fill bits set");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid && s_axis_tready)
        else $error("pipeline not empty after reset");

    // a request taken while no result is shown leads to a shown result, not always its own
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> ##1 m_axis_tvalid)
        else $error("result missing after request");

endmodule

bind robot_motor_encoder_slave rmes_checker u_rmes_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

### dv/robot_motor_encoder_slave_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// robot_motor_encoder_slave_tb
// Self-checking bench for the motor and encoder bus slave. A mirror of the
// slave state predicts one result per request and compares it field by field
// with what leaves the result channel. Directed requests cover the bus write
// and read sequences, debounce, count wrap and timeout saturation. Random
// phases follow under several register settings, with random idling on both
// channels.
// ----------------------------------------------------------------------------

import rmes_pkg::*;

// mirror of the slave state, holding the results still due
class encoder_slave_mirror;
    logic [7:0]  tick_divide;
    logic [7:0]  timeout_limit;
    logic [7:0]  tick_divider;
    logic [1:0]  debounce_l;
    logic [1:0]  debounce_r;
    logic [7:0]  timeout_count;
    logic [15:0] count_l;
    logic [15:0] count_r;
    logic [1:0]  bumper;
    logic [2:0]  current_hi;
    logic [6:0]  current_lo;
    logic [4:0]  write_count;
    logic [7:0]  write_buf [COMMAND_BYTES];
    logic [7:0]  received [COMMAND_BYTES];
    logic        command_pending;
    logic [7:0]  motor [COMMAND_BYTES];
    logic [2:0]  read_idx;
    result_t     due_results [$];
    int          mismatch_count;
    int          results_seen;

    function new();
        tick_divide     = TICK_DIVIDE_RESET;
        timeout_limit   = TIMEOUT_LIMIT_RESET;
        tick_divider    = '0;
        debounce_l      = '0;
        debounce_r      = '0;
        timeout_count   = '0;
        count_l         = '0;
        count_r         = '0;
        bumper          = '0;
        current_hi      = '0;
        current_lo      = '0;
        write_count     = '0;
        command_pending = 1'b0;
        read_idx        = SLOT_BUMPER;
        mismatch_count  = 0;
        results_seen    = 0;
        for (int k = 0; k < COMMAND_BYTES; k++) begin
            write_buf[k] = '0;
            received[k]  = '0;
            motor[k]     = '0;
        end
    endfunction

    task flag_mismatch(string msg);
        $display("%0t ns: result %0d: %s", $time, results_seen, msg);
        mismatch_count++;
    endtask

    // low byte of the current sensor slot, then step to the next slot
    function logic [7:0] read_slot();
        logic [7:0] v;
        if (read_idx >= SENSOR_SLOTS)
            read_idx = SLOT_BUMPER;
        case (read_idx)
            SLOT_BUMPER:       v = {6'd0, bumper};
            SLOT_COUNT_LEFT:   v = count_l[7:0];
            SLOT_COUNT_RIGHT:  v = count_r[7:0];
            SLOT_CURRENT_HIGH: v = {5'd0, current_hi};
            default:           v = {1'b0, current_lo};
        endcase
        read_idx = read_idx + 3'd1;
        return v;
    endfunction

    // update the state for one request and queue the result it causes
    function void apply_request(item_t req);
        result_t    r;
        logic [8:0] next_div;
        r = '0;
        case (req.kind)
            KIND_TICK: begin
                next_div = {1'b0, tick_divider} + 9'd1;
                if (next_div > {1'b0, tick_divide}) begin
                    tick_divider = '0;
                    if (debounce_l < DEBOUNCE_MAX)
                        debounce_l = debounce_l + 2'd1;
                    if (debounce_r < DEBOUNCE_MAX)
                        debounce_r = debounce_r + 2'd1;
                    if (timeout_count != TIMEOUT_MAX)
                        timeout_count = timeout_count + 8'd1;
                end else begin
                    tick_divider = next_div[7:0];
                end
            end
            KIND_LEFT_EDGE: begin
                if (debounce_l == DEBOUNCE_MAX) begin
                    if (motor[0] == DIR_BOTH_FWD || motor[0] == DIR_LEFT_FWD)
                        count_l = count_l + 16'd1;
                    else
                        count_l = count_l - 16'd1;
                    debounce_l = '0;
                end
            end
            KIND_RIGHT_EDGE: begin
                if (debounce_r == DEBOUNCE_MAX) begin
                    if (motor[0] == DIR_BOTH_FWD || motor[0] == DIR_RIGHT_FWD)
                        count_r = count_r + 16'd1;
                    else
                        count_r = count_r - 16'd1;
                    debounce_r = '0;
                end
            end
            KIND_WRITE_START: begin
                write_count = '0;
            end
            KIND_WRITE_BYTE: begin
                if (write_count < COMMAND_BYTES_CNT)
                    write_buf[write_count] = req.data_byte;
                if (write_count < WRITE_COUNT_MAX)
                    write_count = write_count + 5'd1;
            end
            KIND_WRITE_STOP: begin
                // only the bytes actually written are handed over
                for (int k = 0; k < COMMAND_BYTES; k++) begin
                    if (k < write_count)
                        received[k] = write_buf[k];
                    write_buf[k] = '0;
                end
                command_pending = 1'b1;
                timeout_count   = '0;
            end
            KIND_READ_START: begin
                write_count  = '0;
                r.read_data  = read_slot();
                r.read_valid = 1'b1;
            end
            KIND_READ_NEXT: begin
                r.read_data  = read_slot();
                r.read_valid = 1'b1;
                count_l      = COUNT_PRESET;
                count_r      = COUNT_PRESET;
            end
            KIND_POLL: begin
                current_hi = req.current_sample[9:7];
                current_lo = req.current_sample[6:0];
                bumper     = req.bumper_bits;
                // safety stop first, a pending command still wins
                if (bumper != 2'b00 || timeout_count > timeout_limit) begin
                    for (int k = 0; k < COMMAND_BYTES; k++)
                        motor[k] = '0;
                end
                if (command_pending) begin
                    for (int k = 0; k < COMMAND_BYTES; k++)
                        motor[k] = received[k];
                    if (read_idx > SLOT_KEEP_MAX)
                        read_idx = SLOT_BUMPER;
                    command_pending = 1'b0;
                end
            end
            default: begin
            end
        endcase
        r.motor_direction = motor[0][3:0] & DIR_MASK;
        r.pwm_left        = motor[1];
        r.pwm_right       = motor[2];
        due_results.push_back(r);
    endfunction

    task check_field(string name, int got, int want);
        if (got != want)
            flag_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    // compare a result from the slave with the oldest one due
    task match_result(result_t got);
        result_t want;
        results_seen++;
        if (due_results.size() == 0) begin
            flag_mismatch($sformatf("unexpected result, read byte %0h", got.read_data));
            return;
        end
        want = due_results.pop_front();
        check_field("read_data", got.read_data, want.read_data);
        check_field("read_valid", got.read_valid, want.read_valid);
        check_field("motor_direction", got.motor_direction, want.motor_direction);
        check_field("pwm_left", got.pwm_left, want.pwm_left);
        check_field("pwm_right", got.pwm_right, want.pwm_right);
    endtask
endclass

module robot_motor_encoder_slave_tb;

    localparam int         STALL_LIMIT    = 2000;
    localparam int         PHASE_REQUESTS = 32;
    localparam int         SATURATE_TICKS = 520;
    localparam logic [3:0] KIND_UNUSED_LO = 4'd9;
    localparam logic [3:0] KIND_UNUSED_HI = 4'hF;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // data_byte[7:0], bumper_bits[9:8], current_sample[19:10], zero fill
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // kind[3:0]
    logic [3:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // read_data[7:0], motor_direction[11:8], pwm_left[19:12], pwm_right[27:20]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // read_valid[0]
    logic [0:0]             m_axis_tuser;
    logic                   cfg_we;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [7:0]             cfg_wdata;

    encoder_slave_mirror    sb;
    bit                     calm;
    int                     requests_sent;

    robot_motor_encoder_slave DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    // 12 ns clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // offer one request after a random gap and hold it until taken
    task automatic send_request(input logic [3:0] kind, input logic [7:0] data,
                                input logic [1:0] bumps, input logic [9:0] sample);
        int gap;
        if ($urandom_range(0, 29) == 0)
            calm = !calm;
        gap = calm ? 0 : $urandom_range(0, 14);
        @(negedge aclk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {4'd0, sample, bumps, data};
        do @(posedge aclk); while (!s_axis_tready);
        requests_sent++;
    endtask

    // request whose other fields are noise
    task automatic send_kind(input logic [3:0] kind);
        send_request(kind, 8'($urandom), 2'($urandom), 10'($urandom));
    endtask

    task automatic random_poll();
        send_request(KIND_POLL, 8'($urandom),
                     ($urandom_range(0, 3) == 0) ? 2'($urandom_range(1, 3)) : 2'b00,
                     10'($urandom));
    endtask

    // stop offering and wait until every result has come back
    task automatic drain_results();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_config(input logic [CFG_ADDR_W-1:0] addr, input logic [7:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        if (addr == CFG_TICK_DIVIDE)
            sb.tick_divide = value;
        else
            sb.timeout_limit = value;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // one random bus exchange, mostly well-formed sequences
    task automatic random_exchange();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 28) begin
            // write: start, command bytes, stop, usually a poll to latch it
            case ($urandom_range(0, 9))
                0:       n = $urandom_range(21, 40);
                1:       n = $urandom_range(0, 2);
                2:       n = $urandom_range(4, 5);
                default: n = 3;
            endcase
            if ($urandom_range(0, 9) != 0)
                send_kind(KIND_WRITE_START);
            for (int i = 0; i < n; i++) begin
                if (i == 0 && $urandom_range(0, 3) != 0)
                    send_request(KIND_WRITE_BYTE, {4'd0, 2'($urandom), 2'd0},
                                 2'($urandom), 10'($urandom));
                else
                    send_kind(KIND_WRITE_BYTE);
            end
            if ($urandom_range(0, 9) != 0)
                send_kind(KIND_WRITE_STOP);
            if ($urandom_range(0, 2) != 0)
                random_poll();
        end else if (pick < 43) begin
            // read: start then a run of next reads
            if ($urandom_range(0, 9) != 0)
                send_kind(KIND_READ_START);
            n = $urandom_range(0, 6);
            repeat (n) send_kind(KIND_READ_NEXT);
        end else if (pick < 68) begin
            n = $urandom_range(1, 40);
            repeat (n) send_kind(KIND_TICK);
        end else if (pick < 83) begin
            n = $urandom_range(1, 4);
            repeat (n) send_kind($urandom_range(0, 1) ? KIND_LEFT_EDGE : KIND_RIGHT_EDGE);
        end else if (pick < 93) begin
            random_poll();
        end else begin
            send_kind(4'($urandom));
        end
    endtask

    // result side: random stall before each result
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            stall = calm ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (m_axis_tvalid !== 1'b1);
        end
    end

    // note accepted requests, then check accepted results
    always @(posedge aclk) begin : monitor
        item_t   seen;
        result_t got;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                seen.kind           = s_axis_tuser;
                seen.data_byte      = s_axis_tdata[7:0];
                seen.bumper_bits    = s_axis_tdata[9:8];
                seen.current_sample = s_axis_tdata[19:10];
                sb.apply_request(seen);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.read_data       = m_axis_tdata[7:0];
                got.motor_direction = m_axis_tdata[11:8];
                got.pwm_left        = m_axis_tdata[19:12];
                got.pwm_right       = m_axis_tdata[27:20];
                got.read_valid      = m_axis_tuser[0];
                sb.match_result(got);
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("robot_motor_encoder_slave_tb: errors");
        $finish;
    end

    // main sequence
    initial begin
        int         phase_end;
        logic [7:0] td;
        logic [7:0] tl;
        sb            = new();
        calm          = 1'b0;
        requests_sent = 0;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: short periods, no timeout margin
        write_config(CFG_TICK_DIVIDE, 8'd1);
        write_config(CFG_TIMEOUT_LIMIT, 8'd0);
        send_request(KIND_POLL, 8'h00, 2'b00, 10'h3FF);
        // write with one byte beyond the buffer
        send_kind(KIND_WRITE_START);
        send_request(KIND_WRITE_BYTE, 8'hFF, 2'b00, 10'h000);
        send_request(KIND_WRITE_BYTE, 8'hAA, 2'b11, 10'h3FF);
        send_request(KIND_WRITE_BYTE, 8'h55, 2'b00, 10'h000);
        send_request(KIND_WRITE_BYTE, 8'h00, 2'b11, 10'h3FF);
        send_kind(KIND_WRITE_STOP);
        // bump clears the motors but the pending command is latched after
        send_request(KIND_POLL, 8'h00, 2'b11, 10'h000);
        repeat (4) send_kind(KIND_TICK);
        // reverse direction: counts wrap below zero, the repeated left edge is bounced
        send_kind(KIND_LEFT_EDGE);
        send_kind(KIND_LEFT_EDGE);
        send_kind(KIND_RIGHT_EDGE);
        // read every slot and wrap round to the first
        send_kind(KIND_READ_START);
        repeat (5) send_kind(KIND_READ_NEXT);
        // link timeout stops the motors
        repeat (2) send_kind(KIND_TICK);
        send_request(KIND_POLL, 8'hFF, 2'b00, 10'h000);
        // empty write keeps the previous command
        send_kind(KIND_WRITE_START);
        send_kind(KIND_WRITE_STOP);
        send_request(KIND_POLL, 8'h00, 2'b00, 10'h080);
        send_kind(KIND_READ_START);
        send_kind(KIND_UNUSED_LO);
        send_kind(KIND_UNUSED_HI);

        // timeout counter must stick at its top value
        drain_results();
        write_config(CFG_TIMEOUT_LIMIT, 8'd254);
        send_kind(KIND_WRITE_START);
        // both direction bits set: both wheels reverse
        send_request(KIND_WRITE_BYTE, {4'd0, DIR_MASK}, 2'b00, 10'h000);
        send_request(KIND_WRITE_BYTE, 8'h40, 2'b00, 10'h000);
        send_request(KIND_WRITE_BYTE, 8'h41, 2'b00, 10'h000);
        send_kind(KIND_WRITE_STOP);
        send_request(KIND_POLL, 8'h00, 2'b00, 10'h155);
        repeat (SATURATE_TICKS) send_kind(KIND_TICK);
        send_request(KIND_POLL, 8'h00, 2'b00, 10'h2AA);

        // random phases under different register settings
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    td = TICK_DIVIDE_RESET;
                    tl = TIMEOUT_LIMIT_RESET;
                end
                1: begin
                    td = 8'd255;
                    tl = 8'd255;
                end
                2: begin
                    td = 8'd1;
                    tl = 8'd0;
                end
                3: begin
                    td = 8'($urandom_range(2, 8));
                    tl = 8'($urandom_range(0, 6));
                end
                default: begin
                    td = 8'($urandom_range(1, 255));
                    tl = 8'($urandom_range(0, 255));
                end
            endcase
            drain_results();
            write_config(CFG_TICK_DIVIDE, td);
            write_config(CFG_TIMEOUT_LIMIT, tl);
            phase_end = requests_sent + PHASE_REQUESTS;
            while (requests_sent < phase_end)
                random_exchange();
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (sb.due_results.size() != 0)
            sb.flag_mismatch($sformatf("%0d results never arrived", sb.due_results.size()));
        if (sb.mismatch_count == 0)
            $display("robot_motor_encoder_slave_tb: clean");
        else
            $display("robot_motor_encoder_slave_tb: errors");
        $finish;
    end

endmodule
